/* src/hbs_pkg.sv */
// shared types, constants and arithmetic helpers of the heightmap bilinear sampler
package hbs_pkg;

   // storage and number formats
   localparam int STORE_DEPTH = 262144;               // power of two
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FRAC_BITS   = 8;
   localparam int FRAC_W      = FRAC_BITS + 1;        // fraction bits after halving
   localparam int HGT_W       = 16;
   localparam int CO_W        = 18;
   localparam int WIDX_W      = 18;
   localparam int SIDE_W      = 10;
   localparam int CELL_W      = CO_W - FRAC_W;
   localparam int IDX_W       = CELL_W + SIDE_W + 1;
   localparam int A_W         = HGT_W + FRAC_W;       // first lerp, units 2^-FRAC_W
   localparam int H_W         = A_W + FRAC_W;         // second lerp, units 2^-2*FRAC_W
   localparam int SHIFT       = 2 * FRAC_W - FRAC_BITS;
   localparam int OUT_W       = 24;

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(512);

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_SIDE_LEN     = 1'b0,
      CSR_BOUNDS_CHECK = 1'b1
   } csr_index_type;

   // neighbour order within one sample
   typedef enum logic [1:0] {
      SLOT_P1 = 2'd0,
      SLOT_P2 = 2'd1,
      SLOT_P3 = 2'd2,
      SLOT_P4 = 2'd3
   } slot_type;

   // one memory read returning to the interpolator
   typedef struct packed {
      logic              valid;
      slot_type          slot;
      logic              zero;
      logic [FRAC_W-1:0] fx;
      logic [FRAC_W-1:0] fy;
      logic [HGT_W-1:0]  data;
   } hbs_rd_type;

   // lo*2^FRAC_W + (hi-lo)*f, never negative
   function automatic logic [A_W-1:0] lerp_first(input logic [HGT_W-1:0] lo,
                                                input logic [HGT_W-1:0] hi,
                                                input logic [FRAC_W-1:0] f);
      logic signed [HGT_W:0] d;
      logic signed [A_W+1:0] de;
      logic signed [A_W+1:0] fe;
      logic signed [A_W+1:0] s;
      d  = $signed({1'b0, hi}) - $signed({1'b0, lo});
      de = (A_W+2)'(d);
      fe = $signed({{(A_W+2-FRAC_W){1'b0}}, f});
      s  = de * fe + $signed({2'b00, lo, {FRAC_W{1'b0}}});
      return s[A_W-1:0];
   endfunction

   // lo*2^FRAC_W + (hi-lo)*f on first-lerp values, never negative
   function automatic logic [H_W-1:0] lerp_second(input logic [A_W-1:0] lo,
                                                 input logic [A_W-1:0] hi,
                                                 input logic [FRAC_W-1:0] f);
      logic signed [A_W:0]   d;
      logic signed [H_W+1:0] de;
      logic signed [H_W+1:0] fe;
      logic signed [H_W+1:0] s;
      d  = $signed({1'b0, hi}) - $signed({1'b0, lo});
      de = (H_W+2)'(d);
      fe = $signed({{(H_W+2-FRAC_W){1'b0}}, f});
      s  = de * fe + $signed({2'b00, lo, {FRAC_W{1'b0}}});
      return s[H_W-1:0];
   endfunction

endpackage

/* src/hbs_interp.sv */
// bilinear interpolation pipeline fed by the neighbour reads
module hbs_interp (
   input  logic                      clock,
   input  logic                      reset,
   input  hbs_pkg::hbs_rd_type       rd,
   output logic                      rsp_valid,
   output logic [hbs_pkg::OUT_W-1:0] rsp_height_fixed
);
   import hbs_pkg::*;

   logic [HGT_W-1:0]  p1_ff, p2_ff;
   logic [A_W-1:0]    a_ff, b_ff;
   logic [FRAC_W-1:0] fy_ff;
   logic              mix_valid_ff, mix_valid_in;
   logic              out_valid_ff;
   logic [OUT_W-1:0]  out_ff, out_in;
   logic [HGT_W-1:0]  pval;
   logic [H_W-1:0]    h;
   logic [55:0]       h_scaled;

   assign pval = rd.zero ? '0 : rd.data;
   assign mix_valid_in = rd.valid && (rd.slot == SLOT_P4);

   always_ff @(posedge clock) begin
      if (rd.valid) begin
         unique case (rd.slot)
            SLOT_P1: p1_ff <= pval;
            SLOT_P2: p2_ff <= pval;
            SLOT_P3: a_ff  <= lerp_first(p1_ff, pval, rd.fx);
            SLOT_P4: begin
               b_ff  <= lerp_first(p2_ff, pval, rd.fx);
               fy_ff <= rd.fy;
            end
            default: ;
         endcase
      end
   end

   // final lerp, truncate and saturate
   always_comb begin
      h        = lerp_second(a_ff, b_ff, fy_ff);
      h_scaled = 56'(h) >> SHIFT;
      out_in   = (h_scaled > 56'hFF_FFFF) ? '1 : h_scaled[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mix_valid_ff <= mix_valid_in;
         out_valid_ff <= mix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mix_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_height_fixed = out_ff;

endmodule

/* src/heightmap_bilinear_sample_top.sv */
// top level of the heightmap bilinear sampler: store, read sequencer and config
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+----------------------------
//   request  | req_func, req_write_index,              | taken when start & !busy
//            | req_write_height, req_coord_x/y         |
//   result   | rsp_height_fixed                        | rsp_valid, one cycle, no stall
//   config   | csr_index, csr_wdata                    | csr_we, written at once
//
// a sample item makes four neighbour reads on the single height memory port, one read
// per cycle; a write item makes one write, so writes can come every cycle
// the result strobe follows the last neighbour read via the read, mix and output registers
// busy is low in the last port cycle of an item, so the next item follows directly
// reset is synchronous; the store itself is not cleared and holds garbage until written
// the receiver cannot stall: results leave on a fixed schedule
module heightmap_bilinear_sample_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_func,
   input  logic [hbs_pkg::WIDX_W-1:0] req_write_index,
   input  logic [hbs_pkg::HGT_W-1:0]  req_write_height,
   input  logic [hbs_pkg::CO_W-1:0]   req_coord_x,
   input  logic [hbs_pkg::CO_W-1:0]   req_coord_y,
   output logic                       rsp_valid,
   output logic [hbs_pkg::OUT_W-1:0]  rsp_height_fixed,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [hbs_pkg::SIDE_W-1:0] csr_wdata
);
   import hbs_pkg::*;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WRITE = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   // configuration
   logic [SIDE_W-1:0] side_ff;
   logic              bounds_ff;

   // sequencer
   state_type         state_ff, state_in;
   slot_type          slot_ff, slot_in;
   logic              accept;

   // captured item
   logic [IDX_W-1:0]  base_ff, base_in;
   logic [FRAC_W-1:0] fx_ff, fy_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic              wr_ok_ff;
   logic [HGT_W-1:0]  wr_data_ff;

   // item decode at the input
   logic [CELL_W-1:0] xi, yi;
   logic [31:0]       widx32;

   // port address for the current neighbour
   logic [IDX_W-1:0]  offset;
   logic [IDX_W-1:0]  idx;
   logic [31:0]       idx32;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_oob;
   logic              reading;

   // height store and its read return
   logic [HGT_W-1:0]  store_mem [STORE_DEPTH];
   logic [HGT_W-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   slot_type          rd_slot_ff;
   logic              rd_zero_ff;
   logic [FRAC_W-1:0] rd_fx_ff, rd_fy_ff;
   hbs_rd_type        rd;

   // busy only while a sample still has reads to issue after this cycle
   assign busy   = (state_ff == ST_READ) && (slot_ff != SLOT_P4);
   assign accept = start && !busy;

   // config writes land at once
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= SIDE_RESET;
         bounds_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIDE_LEN:     side_ff   <= csr_wdata;
            CSR_BOUNDS_CHECK: bounds_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // halve the coordinates: integer cell and fraction, row base yi + xi*side
   always_comb begin
      xi      = req_coord_x[CO_W-1:FRAC_W];
      yi      = req_coord_y[CO_W-1:FRAC_W];
      base_in = IDX_W'(xi) * IDX_W'(side_ff) + IDX_W'(yi);
      widx32  = 32'(req_write_index);
   end

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      priority if (accept) begin
         state_in = req_func ? ST_READ : ST_WRITE;
         slot_in  = SLOT_P1;
      end else if (busy) begin
         slot_in  = slot_type'(slot_ff + 2'd1);
      end else begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= SLOT_P1;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff    <= base_in;
         fx_ff      <= req_coord_x[FRAC_W-1:0];
         fy_ff      <= req_coord_y[FRAC_W-1:0];
         wr_addr_ff <= widx32[ADDR_W-1:0];
         wr_ok_ff   <= widx32 < 32'(STORE_DEPTH);
         wr_data_ff <= req_write_height;
      end
   end

   // neighbours in order p1, p2 (next column), p3, p4 (next row)
   always_comb begin
      unique case (slot_ff)
         SLOT_P1: offset = '0;
         SLOT_P2: offset = IDX_W'(1);
         SLOT_P3: offset = IDX_W'(side_ff);
         SLOT_P4: offset = IDX_W'(side_ff) + IDX_W'(1);
         default: offset = '0;
      endcase
      idx     = base_ff + offset;
      idx32   = 32'(idx);
      rd_addr = idx32[ADDR_W-1:0];           // wraps modulo the depth
      rd_oob  = idx32 >= 32'(STORE_DEPTH);
      reading = (state_ff == ST_READ);
   end

   // single port: one write or one read per cycle, in item order
   always_ff @(posedge clock) begin
      if ((state_ff == ST_WRITE) && wr_ok_ff) begin
         store_mem[wr_addr_ff] <= wr_data_ff;
      end
      if (reading) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // side info travels with each read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= reading;
      end
   end

   always_ff @(posedge clock) begin
      if (reading) begin
         rd_slot_ff <= slot_ff;
         rd_zero_ff <= rd_oob && bounds_ff;
         rd_fx_ff   <= fx_ff;
         rd_fy_ff   <= fy_ff;
      end
   end

   always_comb begin
      rd.valid = rd_valid_ff;
      rd.slot  = rd_slot_ff;
      rd.zero  = rd_zero_ff;
      rd.fx    = rd_fx_ff;
      rd.fy    = rd_fy_ff;
      rd.data  = rd_data_ff;
   end

   hbs_interp u_interp (
      .clock            (clock),
      .reset            (reset),
      .rd               (rd),
      .rsp_valid        (rsp_valid),
      .rsp_height_fixed (rsp_height_fixed)
   );

endmodule

/* src/hbs_checker.sv */
// port-level checker for the heightmap sampler, bound to the top level
module hbs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_valid
);
   logic take_sample;
   logic take_write;

   assign take_sample = start && !busy && req_func;
   assign take_write  = start && !busy && !req_func;

   // a sample holds busy through its first three reads and drops it for the fourth
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> busy ##1 busy ##1 busy ##1 !busy)
      else $error("sample did not hold busy for its reads");

   // a write never stalls the next item
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      take_write |=> !busy)
      else $error("busy after a write item");

   // every sample gives its result after a fixed latency
   a_sample_result: assert property (@(posedge clock) disable iff (reset)
      take_sample |-> ##7 rsp_valid)
      else $error("sample result missing");

   // results come only from samples, at most one per port slot group
   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("results closer than a sample allows");

endmodule

bind heightmap_bilinear_sample_top hbs_checker u_hbs_checker (.*);
